// ===== sv/scp_pkg.sv =====
// Shared constants, coefficient tables and types of the sine/cosine polynomial core.
package scp_pkg;

    localparam int OUT_W = 32;
    localparam int OUT_DATA_W = 2 * OUT_W;
    localparam int MUL_LAT = 3;
    localparam int NUM_COS = 7;
    localparam int NUM_SIN = 6;

    typedef struct packed {
        logic [63:0] mant;
        logic [2:0]  dexp;
        logic        neg;
    } dec_coef_t;

    // Powers of ten from 10^16 to 10^20, selected by the decimal exponent offset.
    localparam logic [127:0] DEC_SCALE [5] = '{
        128'd10000000000000000,
        128'd100000000000000000,
        128'd1000000000000000000,
        128'd10000000000000000000,
        128'd100000000000000000000
    };

    // Each entry is mant / 10^(16 + dexp), negated when neg is set.
    localparam dec_coef_t COS_TAB [NUM_COS] = '{
        '{64'd10369917389758117, 3'd4, 1'b1},
        '{64'd19294935641298806, 3'd3, 1'b0},
        '{64'd25806887942825395, 3'd2, 1'b1},
        '{64'd23533063028328211, 3'd1, 1'b0},
        '{64'd13352627688538006, 3'd0, 1'b1},
        '{64'd40587121264167623, 3'd0, 1'b0},
        '{64'd49348022005446790, 3'd0, 1'b1}
    };

    localparam dec_coef_t SIN_TAB [NUM_SIN] = '{
        '{64'd46151442520157035, 3'd4, 1'b0},
        '{64'd73700183130883555, 3'd3, 1'b1},
        '{64'd82145868949323936, 3'd2, 1'b0},
        '{64'd59926452893214921, 3'd1, 1'b1},
        '{64'd25501640398732688, 3'd0, 1'b0},
        '{64'd51677127800499516, 3'd0, 1'b1}
    };

    localparam dec_coef_t PI_COEF = '{64'd31415926535897931, 3'd0, 1'b0};

endpackage

// ===== sv/sincos_pi_polynomial_core.sv =====
// Top level of the sine/cosine polynomial core: phase split, Horner pipelines and output buffer.
//
// Takes one phase per clock and returns sin(pi*a) and cos(pi*a) with OUT_FRAC_BITS fractional
// bits, where a = phase / 2^(PHASE_WIDTH-1). The datapath is a fixed pipeline of
// 8 * 3 + 3 = 27 register stages, set by the cosine path: one phase-split stage, eight chained
// three-stage multiply-round units (t squared, then seven Horner steps in t squared) and two
// output stages for rescaling, quadrant mapping and saturation ahead of the output register.
// A new phase may be accepted in every cycle while the skid register is empty. A one-entry
// skid register behind the output register lets the pipeline keep moving while a result waits;
// when it is full the whole pipeline holds.
module sincos_pi_polynomial_core #(
    parameter int PHASE_WIDTH     = 32,
    parameter int OUT_FRAC_BITS   = 30,
    parameter int INNER_FRAC_BITS = 40,
    localparam int S_DATA_W       = ((PHASE_WIDTH + 7) / 8) * 8
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [S_DATA_W-1:0]              s_tdata,   // [PHASE_WIDTH-1:0] phase
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [scp_pkg::OUT_DATA_W-1:0]   m_tdata    // [31:0] sine, [63:32] cosine
);

    localparam int VW  = INNER_FRAC_BITS + 4;
    localparam int ML  = scp_pkg::MUL_LAT;
    localparam int NST = 8 * ML + 3;
    localparam int PW  = PHASE_WIDTH;
    localparam bit T_UP = (INNER_FRAC_BITS >= PW - 1);
    localparam int TUP = T_UP ? INNER_FRAC_BITS - (PW - 1) : 0;
    localparam int TDN = T_UP ? 1 : (PW - 1) - INNER_FRAC_BITS;
    localparam logic signed [VW-1:0] ONE_V = VW'(1) << INNER_FRAC_BITS;
    localparam logic [127:0] PI_DEN = scp_pkg::DEC_SCALE[scp_pkg::PI_COEF.dexp];
    localparam logic [127:0] PI_MAG =
        ((128'(scp_pkg::PI_COEF.mant) << INNER_FRAC_BITS) + (PI_DEN >> 1)) / PI_DEN;
    localparam logic signed [VW-1:0] PI_V = VW'(PI_MAG);

    function automatic logic signed [VW-1:0] t_from_phase(input logic [PW-1:0] ph);
        logic signed [PW-3:0] tr;
        logic [PW-2:0]        m;
        logic [PW-2:0]        r;
        tr = signed'(ph[PW-3:0]);
        m = {1'b0, tr[PW-3] ? -tr : tr};
        r = (m + ((PW-1)'(1) << (TDN - 1))) >> TDN;
        if (T_UP) begin
            return VW'(tr) <<< TUP;
        end
        return tr[PW-3] ? -VW'(r) : VW'(r);
    endfunction

    logic signed [VW-1:0] cos_coef [scp_pkg::NUM_COS];
    logic signed [VW-1:0] sin_coef [scp_pkg::NUM_SIN];

    for (genvar k = 0; k < scp_pkg::NUM_COS; k++) begin : g_cos_coef
        localparam logic [127:0] DEN = scp_pkg::DEC_SCALE[scp_pkg::COS_TAB[k].dexp];
        localparam logic [127:0] MAG =
            ((128'(scp_pkg::COS_TAB[k].mant) << INNER_FRAC_BITS) + (DEN >> 1)) / DEN;
        assign cos_coef[k] = scp_pkg::COS_TAB[k].neg ? -VW'(MAG) : VW'(MAG);
    end

    for (genvar k = 0; k < scp_pkg::NUM_SIN; k++) begin : g_sin_coef
        localparam logic [127:0] DEN = scp_pkg::DEC_SCALE[scp_pkg::SIN_TAB[k].dexp];
        localparam logic [127:0] MAG =
            ((128'(scp_pkg::SIN_TAB[k].mant) << INNER_FRAC_BITS) + (DEN >> 1)) / DEN;
        assign sin_coef[k] = scp_pkg::SIN_TAB[k].neg ? -VW'(MAG) : VW'(MAG);
    end

    logic                 en;
    logic                 skid_vld_reg, skid_vld_next;
    logic [NST-1:0]       vld_reg;
    logic signed [VW-1:0] t0_reg;
    logic [1:0]           q0_reg;
    logic [PW-1:0]        phase;

    assign phase    = s_tdata[PW-1:0];
    assign en       = !skid_vld_reg;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NST-2:0], s_tvalid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            t0_reg <= t_from_phase(phase);
            q0_reg <= phase[PW-1:PW-2] + 2'(phase[PW-3]);
        end
    end

    // t squared, feeding every Horner step through a chain of delays.
    logic signed [VW-1:0] s_pipe [scp_pkg::NUM_COS];
    logic signed [VW-1:0] pi_t;
    logic signed [VW-1:0] t_d1;

    scp_mulr #(.VW(VW), .FRAC(INNER_FRAC_BITS)) u_sq (
        .aclk(aclk), .en(en), .a(t0_reg), .b(t0_reg), .c('0), .y(s_pipe[0])
    );

    scp_mulr #(.VW(VW), .FRAC(INNER_FRAC_BITS)) u_pit (
        .aclk(aclk), .en(en), .a(t0_reg), .b(PI_V), .c('0), .y(pi_t)
    );

    scp_delay #(.WIDTH(VW), .DEPTH(ML)) u_t_dly (
        .aclk(aclk), .en(en), .din(t0_reg), .dout(t_d1)
    );

    for (genvar k = 1; k < scp_pkg::NUM_COS; k++) begin : g_s_dly
        scp_delay #(.WIDTH(VW), .DEPTH(ML)) u_s_dly (
            .aclk(aclk), .en(en), .din(s_pipe[k-1]), .dout(s_pipe[k])
        );
    end

    // Cosine Horner chain; the last step adds one.
    logic signed [VW-1:0] cos_a [1:scp_pkg::NUM_COS];
    logic signed [VW-1:0] cos_c [1:scp_pkg::NUM_COS];
    logic signed [VW-1:0] cos_r [1:scp_pkg::NUM_COS];

    for (genvar k = 1; k <= scp_pkg::NUM_COS; k++) begin : g_cos
        if (k == 1) begin : g_first
            assign cos_a[k] = cos_coef[0];
        end else begin : g_next
            assign cos_a[k] = cos_r[k-1];
        end
        if (k < scp_pkg::NUM_COS) begin : g_coef
            assign cos_c[k] = cos_coef[k];
        end else begin : g_one
            assign cos_c[k] = ONE_V;
        end
        scp_mulr #(.VW(VW), .FRAC(INNER_FRAC_BITS)) u_step (
            .aclk(aclk), .en(en), .a(cos_a[k]), .b(s_pipe[k-1]), .c(cos_c[k]), .y(cos_r[k])
        );
    end

    // Sine Horner chain.
    logic signed [VW-1:0] sin_a [1:scp_pkg::NUM_SIN-1];
    logic signed [VW-1:0] sin_r [1:scp_pkg::NUM_SIN-1];

    for (genvar k = 1; k < scp_pkg::NUM_SIN; k++) begin : g_sin
        if (k == 1) begin : g_first
            assign sin_a[k] = sin_coef[0];
        end else begin : g_next
            assign sin_a[k] = sin_r[k-1];
        end
        scp_mulr #(.VW(VW), .FRAC(INNER_FRAC_BITS)) u_step (
            .aclk(aclk), .en(en), .a(sin_a[k]), .b(s_pipe[k-1]), .c(sin_coef[k]), .y(sin_r[k])
        );
    end

    logic signed [VW-1:0] st, st_d, pi_t_d, sn, sn_d;
    logic [1:0]           q_d;

    scp_mulr #(.VW(VW), .FRAC(INNER_FRAC_BITS)) u_st (
        .aclk(aclk), .en(en), .a(s_pipe[0]), .b(t_d1), .c('0), .y(st)
    );

    scp_delay #(.WIDTH(VW), .DEPTH(4 * ML)) u_st_dly (
        .aclk(aclk), .en(en), .din(st), .dout(st_d)
    );

    scp_delay #(.WIDTH(VW), .DEPTH(5 * ML)) u_pit_dly (
        .aclk(aclk), .en(en), .din(pi_t), .dout(pi_t_d)
    );

    scp_mulr #(.VW(VW), .FRAC(INNER_FRAC_BITS)) u_sn (
        .aclk(aclk), .en(en), .a(sin_r[scp_pkg::NUM_SIN-1]), .b(st_d), .c(pi_t_d), .y(sn)
    );

    scp_delay #(.WIDTH(VW), .DEPTH(ML)) u_sn_dly (
        .aclk(aclk), .en(en), .din(sn), .dout(sn_d)
    );

    scp_delay #(.WIDTH(2), .DEPTH(8 * ML)) u_q_dly (
        .aclk(aclk), .en(en), .din(q0_reg), .dout(q_d)
    );

    logic signed [scp_pkg::OUT_W-1:0] sine_p, cosine_p;

    scp_quad_map #(.VW(VW), .IN_FRAC(INNER_FRAC_BITS), .OUT_FRAC(OUT_FRAC_BITS)) u_map (
        .aclk(aclk), .en(en), .sn(sn_d), .cs(cos_r[scp_pkg::NUM_COS]), .quad(q_d),
        .sine(sine_p), .cosine(cosine_p)
    );

    // Output register with a one-entry skid register behind it.
    logic                              p_valid;
    logic [scp_pkg::OUT_DATA_W-1:0]    p_data;
    logic                              out_free;
    logic                              m_vld_reg, m_vld_next;
    logic [scp_pkg::OUT_DATA_W-1:0]    m_data_reg, skid_data_reg;

    assign p_valid  = vld_reg[NST-1];
    assign p_data   = {cosine_p, sine_p};
    assign out_free = !m_vld_reg || m_tready;

    always_comb begin
        m_vld_next    = m_vld_reg;
        skid_vld_next = skid_vld_reg;
        if (out_free) begin
            m_vld_next    = skid_vld_reg || (en && p_valid);
            skid_vld_next = 1'b0;
        end else if (en && p_valid) begin
            skid_vld_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_vld_reg    <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else begin
            m_vld_reg    <= m_vld_next;
            skid_vld_reg <= skid_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            m_data_reg <= skid_vld_reg ? skid_data_reg : p_data;
        end else if (en && p_valid) begin
            skid_data_reg <= p_data;
        end
    end

    assign m_tvalid = m_vld_reg;
    assign m_tdata  = m_data_reg;

    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_vld_reg |-> m_vld_reg)
        else $error("Skid register holds a result while the output register is empty.");

    a_hold_on_full: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_vld_reg |=> $stable(vld_reg))
        else $error("Pipeline moved while the skid register was full.");

    a_skid_catch: assert property (@(posedge aclk) disable iff (!aresetn)
        (en && p_valid && m_vld_reg && !m_tready) |=> skid_vld_reg)
        else $error("A finished result was dropped while the output was stalled.");

    a_out_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_vld_reg) |-> $past(vld_reg[NST-1]))
        else $error("Output became valid without a result from the pipeline.");

endmodule

// ===== sv/scp_delay.sv =====
// Enabled shift-register delay line for pipeline side data.
module scp_delay #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [WIDTH-1:0] din,
    output logic [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] dly_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (en) begin
            dly_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++) begin
                dly_reg[i] <= dly_reg[i-1];
            end
        end
    end

    assign dout = dly_reg[DEPTH-1];

endmodule

// ===== sv/scp_mulr.sv =====
// Three-stage signed multiply with round-to-nearest (ties away from zero) and exact add.
module scp_mulr #(
    parameter int VW   = 44,
    parameter int FRAC = 40
) (
    input  logic                 aclk,
    input  logic                 en,
    input  logic signed [VW-1:0] a,
    input  logic signed [VW-1:0] b,
    input  logic signed [VW-1:0] c,
    output logic signed [VW-1:0] y
);

    localparam int H  = VW / 2;
    localparam int HW = VW - H;
    localparam int PW = 2 * VW;
    localparam logic [PW-1:0] RND = PW'(1) << (FRAC - 1);

    logic [VW-1:0]           am;
    logic [VW-1:0]           bm;
    logic [2*H-1:0]          pp_ll_next, pp_ll_reg;
    logic [H+HW-1:0]         pp_lh_next, pp_lh_reg;
    logic [H+HW-1:0]         pp_hl_next, pp_hl_reg;
    logic [2*HW-1:0]         pp_hh_next, pp_hh_reg;
    logic                    neg1_reg, neg2_reg;
    logic signed [VW-1:0]    c1_reg, c2_reg;
    logic [PW-1:0]           sum_next, sum_reg;
    logic [VW-1:0]           rm;
    logic signed [VW-1:0]    y_next, y_reg;

    // Magnitudes are split in halves so that each partial product stays narrow.
    always_comb begin
        am = a[VW-1] ? -a : a;
        bm = b[VW-1] ? -b : b;
        pp_ll_next = (2*H)'(am[H-1:0]) * (2*H)'(bm[H-1:0]);
        pp_lh_next = (H+HW)'(am[H-1:0]) * (H+HW)'(bm[VW-1:H]);
        pp_hl_next = (H+HW)'(am[VW-1:H]) * (H+HW)'(bm[H-1:0]);
        pp_hh_next = (2*HW)'(am[VW-1:H]) * (2*HW)'(bm[VW-1:H]);
    end

    always_comb begin
        sum_next = PW'(pp_ll_reg) + (PW'(pp_lh_reg) << H) + (PW'(pp_hl_reg) << H)
                 + (PW'(pp_hh_reg) << (2*H)) + RND;
    end

    always_comb begin
        rm = sum_reg[FRAC +: VW];
        y_next = (neg2_reg ? -signed'(rm) : signed'(rm)) + c2_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pp_ll_reg <= pp_ll_next;
            pp_lh_reg <= pp_lh_next;
            pp_hl_reg <= pp_hl_next;
            pp_hh_reg <= pp_hh_next;
            neg1_reg  <= a[VW-1] ^ b[VW-1];
            c1_reg    <= c;
            sum_reg   <= sum_next;
            neg2_reg  <= neg1_reg;
            c2_reg    <= c1_reg;
            y_reg     <= y_next;
        end
    end

    assign y = y_reg;

endmodule

// ===== sv/scp_quad_map.sv =====
// Output rescaling, quadrant mapping and saturation of the sine/cosine pair.
module scp_quad_map #(
    parameter int VW       = 44,
    parameter int IN_FRAC  = 40,
    parameter int OUT_FRAC = 30
) (
    input  logic                                aclk,
    input  logic                                en,
    input  logic signed [VW-1:0]                sn,
    input  logic signed [VW-1:0]                cs,
    input  logic [1:0]                          quad,
    output logic signed [scp_pkg::OUT_W-1:0]    sine,
    output logic signed [scp_pkg::OUT_W-1:0]    cosine
);

    localparam bit UP_MODE = (OUT_FRAC >= IN_FRAC);
    localparam int UP = UP_MODE ? OUT_FRAC - IN_FRAC : 0;
    localparam int DN = UP_MODE ? 1 : IN_FRAC - OUT_FRAC;
    localparam int RW = VW + UP;
    localparam logic signed [RW-1:0] ONE_O = RW'(1) << OUT_FRAC;

    function automatic logic signed [RW-1:0] rescale(input logic signed [VW-1:0] v);
        logic [VW-1:0] m;
        logic [VW-1:0] r;
        m = v[VW-1] ? -v : v;
        r = (m + (VW'(1) << (DN - 1))) >> DN;
        if (UP_MODE) begin
            return RW'(v) <<< UP;
        end
        return v[VW-1] ? -RW'(r) : RW'(r);
    endfunction

    function automatic logic signed [scp_pkg::OUT_W-1:0] sat_one(
        input logic signed [RW-1:0] v
    );
        logic signed [RW-1:0] s;
        s = (v > ONE_O) ? ONE_O : ((v < -ONE_O) ? -ONE_O : v);
        return scp_pkg::OUT_W'(s);
    endfunction

    logic signed [RW-1:0] so_a_reg, co_a_reg;
    logic [1:0]           quad_a_reg;
    logic signed [RW-1:0] so_m, co_m, so_n, co_n;
    logic signed [scp_pkg::OUT_W-1:0] sine_reg, cosine_reg;

    always_comb begin
        so_n = quad_a_reg[1] ? -so_a_reg : so_a_reg;
        co_n = quad_a_reg[1] ? -co_a_reg : co_a_reg;
        so_m = quad_a_reg[0] ? co_n : so_n;
        co_m = quad_a_reg[0] ? -so_n : co_n;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            so_a_reg   <= rescale(sn);
            co_a_reg   <= rescale(cs);
            quad_a_reg <= quad;
            sine_reg   <= sat_one(so_m);
            cosine_reg <= sat_one(co_m);
        end
    end

    assign sine   = sine_reg;
    assign cosine = cosine_reg;

endmodule
